[hdl/sobel_edge_magnitude_3x3_assert.svh]
// Assertion macros shared by the edge magnitude RTL.
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SEM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sem_pkg.sv]
// Shared types and constants of the Sobel edge magnitude block.
package sem_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int PIX_W          = 24;
    localparam int NUM_CHAN       = 3;
    localparam int MAG_W          = 8;
    localparam int GRAD_W         = 11;
    localparam int SQ_W           = 21;
    localparam int ROOT_SRC_W     = 16;
    localparam int REM_W          = 10;
    localparam int ROOT_STEPS     = 8;
    localparam int STEP_W         = 3;
    localparam logic [SQ_W-1:0]  SAT_LIMIT = SQ_W'(65281);
    localparam logic [MAG_W-1:0] MAG_MAX   = 8'd255;

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] pixel_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_pixel;
    } t_pix_out;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef logic [NUM_CHAN-1:0][SQ_W-1:0]  t_chan_sq;
    typedef logic [NUM_CHAN-1:0][MAG_W-1:0] t_chan_mag;

endpackage

[hdl/sem_stream_if.sv]
// Valid/ready channel carrying one payload beat.
interface sem_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/sem_ram.sv]
// Generic simple dual-port RAM with registered read data.
module sem_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/sem_sqrt.sv]
// Three-lane bit-serial rounded square root with saturation at 255.
`include "sobel_edge_magnitude_3x3_assert.svh"

module sem_sqrt
    import sem_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_chan_sq  i_sq,
    output logic      o_valid,
    output t_chan_mag o_mag
);
    logic                                  r_busy;
    logic                                  r_valid;
    logic [STEP_W-1:0]                     r_step;
    logic [NUM_CHAN-1:0]                   r_sat;
    logic [NUM_CHAN-1:0][ROOT_SRC_W-1:0]   r_src;
    logic [NUM_CHAN-1:0][REM_W-1:0]        r_rem;
    logic [NUM_CHAN-1:0][MAG_W-1:0]        r_root;
    logic [NUM_CHAN-1:0][REM_W-1:0]        n_rem;
    logic [NUM_CHAN-1:0][MAG_W-1:0]        n_root;

    always_comb begin
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        for (int k = 0; k < NUM_CHAN; k++) begin
            cur   = {r_rem[k], r_src[k][ROOT_SRC_W-1 -: 2]};
            trial = (REM_W+2)'({r_root[k], 2'b01});
            if (cur >= trial) begin
                n_rem[k]  = REM_W'(cur - trial);
                n_root[k] = {r_root[k][MAG_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = REM_W'(cur);
                n_root[k] = {r_root[k][MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            if (i_start) begin
                r_sat[k]  <= (i_sq[k] >= SAT_LIMIT);
                r_src[k]  <= i_sq[k][ROOT_SRC_W-1:0];
                r_rem[k]  <= '0;
                r_root[k] <= '0;
            end else if (r_busy) begin
                r_src[k]  <= {r_src[k][ROOT_SRC_W-3:0], 2'b00};
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    // Round up when the remainder exceeds the root, that is s > r*r + r.
    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            if (r_sat[k]) begin
                o_mag[k] = MAG_MAX;
            end else if (r_rem[k] > REM_W'(r_root[k])) begin
                o_mag[k] = r_root[k] + MAG_W'(1);
            end else begin
                o_mag[k] = r_root[k];
            end
        end
    end

    assign o_valid = r_valid;

    `SEM_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, i_start, !r_busy, "Root started while busy.")
    `SEM_ASSERT_NEXT(a_finish, i_clk, i_rst_n, r_busy && !i_start && (r_step == STEP_W'(ROOT_STEPS - 1)), r_valid && !r_busy, "Root did not finish after its steps.")
    `SEM_ASSERT_NOW(a_sat_out, i_clk, i_rst_n, r_valid && r_sat[0], o_mag[0] == MAG_MAX, "Saturated lane not at maximum.")
endmodule

[hdl/sobel_edge_magnitude_3x3.sv]
// Top level of the streaming 3x3 Sobel edge magnitude block.
// Pixels enter on i_pix in raster order: mode 0 carries an RGB pixel, mode 1 is a
// drain beat that counts as a black pixel. After the last pixel of a frame the
// source sends frame_width+1 drain beats so that every result leaves.
// i_cfg writes frame_width (index 0) and frame_height (index 1); it is always
// ready and should be used only while no result is pending.
// o_edge carries one beat per pixel position, starting one row and one pixel after
// the first input, with last_pixel set on the final position of the frame.
// Each beat costs a read and a write-back of the line RAM. An input with no result
// passes S_IDLE and S_READ; one with a result also S_GRAD, S_SQUARE, S_LAUNCH and
// S_ROOT, which waits on the 8-step square root shared by the three colour channels.
// A finished result waits in the output register; the block accepts the next
// input meanwhile and holds its own result only if that register is still full.
// Reset clears the counters, the window and the registers to 640 by 480;
// line RAM contents are not cleared and only reach masked border positions.
`include "sobel_edge_magnitude_3x3_assert.svh"

module sobel_edge_magnitude_3x3
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sem_stream_if.sink   i_pix,
    sem_stream_if.source o_edge,
    sem_stream_if.sink   i_cfg
);
    localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int ORW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW  = $clog2(MAX_HEIGHT + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_GRAD   = 3'd2;
    localparam logic [2:0] S_SQUARE = 3'd3;
    localparam logic [2:0] S_LAUNCH = 3'd4;
    localparam logic [2:0] S_ROOT   = 3'd5;

    localparam logic [1:0] ROW_SAT = 2'd2;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_mask;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } t_grad;

    logic [2:0]                     r_state;
    logic [FRAME_WIDTH_W-1:0]       r_frame_width;
    logic [FRAME_HEIGHT_W-1:0]      r_frame_height;
    logic [CW-1:0]                  r_in_col;
    logic [1:0]                     r_in_row;
    logic [CW-1:0]                  r_out_col;
    logic [ORW-1:0]                 r_out_row;
    logic [CW-1:0]                  r_idx;
    logic [PIX_W-1:0]               r_data;
    logic                           r_emit;
    logic [8:0][PIX_W-1:0]          r_win;
    t_mask                          r_mask;
    logic                           r_last;
    t_grad [NUM_CHAN-1:0]           r_grad;
    t_chan_sq                       r_sq;
    logic                           r_out_valid;
    t_pix_out                       r_out;

    logic [WW-1:0]                  w_lim;
    logic [HW-1:0]                  h_lim;
    logic                           pix_acc;
    logic                           cfg_acc;
    logic                           in_wrap;
    logic                           emit_now;
    logic                           col_end;
    logic                           row_end;
    logic                           cur_last;
    logic [2*PIX_W-1:0]             ram_rdata;
    logic [PIX_W-1:0]               up_pix;
    logic [PIX_W-1:0]               mid_pix;
    logic                           ram_we;
    logic                           sqrt_start;
    logic                           sqrt_valid;
    t_chan_mag                      sqrt_mag;
    logic                           out_free;
    logic                           out_load;

    function automatic t_grad chan_grad(input logic [8:0][PIX_W-1:0] win, input t_mask m,
                                        input int ch);
        logic [MAG_W-1:0]  v [3][3];
        logic [GRAD_W-2:0] pos_x;
        logic [GRAD_W-2:0] neg_x;
        logic [GRAD_W-2:0] pos_y;
        logic [GRAD_W-2:0] neg_y;
        t_grad             g;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if ((r == 0 && m.top) || (r == 2 && m.bottom) ||
                    (c == 0 && m.left) || (c == 2 && m.right)) begin
                    v[r][c] = '0;
                end else begin
                    v[r][c] = win[r*3+c][ch*MAG_W +: MAG_W];
                end
            end
        end
        pos_x = (GRAD_W-1)'(v[0][2]) + (GRAD_W-1)'({v[1][2], 1'b0}) + (GRAD_W-1)'(v[2][2]);
        neg_x = (GRAD_W-1)'(v[0][0]) + (GRAD_W-1)'({v[1][0], 1'b0}) + (GRAD_W-1)'(v[2][0]);
        pos_y = (GRAD_W-1)'(v[2][0]) + (GRAD_W-1)'({v[2][1], 1'b0}) + (GRAD_W-1)'(v[2][2]);
        neg_y = (GRAD_W-1)'(v[0][0]) + (GRAD_W-1)'({v[0][1], 1'b0}) + (GRAD_W-1)'(v[0][2]);
        g.gx = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
        g.gy = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
        return g;
    endfunction

    // Frame dimensions with zero taken as one and large values held at the maximum.
    always_comb begin
        if (r_frame_width == '0) begin
            w_lim = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_lim = WW'(MAX_WIDTH);
        end else begin
            w_lim = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_lim = HW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_lim = HW'(MAX_HEIGHT);
        end else begin
            h_lim = HW'(r_frame_height);
        end
    end

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (cfg_acc) begin
            unique case (i_cfg.payload.index)
                REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg.payload.data[FRAME_WIDTH_W-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg.payload.data[FRAME_HEIGHT_W-1:0];
                end
            endcase
        end
    end

    assign i_pix.ready = (r_state == S_IDLE);
    assign pix_acc     = i_pix.valid && i_pix.ready;
    assign in_wrap     = (WW'(r_in_col) + WW'(1)) >= w_lim;
    assign emit_now    = (r_in_row == ROW_SAT) || (r_in_row == 2'd1 && r_in_col != '0);
    assign col_end     = (WW'(r_out_col) + WW'(1)) >= w_lim;
    assign row_end     = (HW'(r_out_row) + HW'(1)) >= h_lim;
    assign cur_last    = col_end && row_end;

    assign up_pix     = ram_rdata[2*PIX_W-1:PIX_W];
    assign mid_pix    = ram_rdata[PIX_W-1:0];
    assign ram_we     = (r_state == S_READ);
    assign sqrt_start = (r_state == S_LAUNCH);
    assign out_free   = !r_out_valid || o_edge.ready;
    assign out_load   = (r_state == S_ROOT) && sqrt_valid && out_free;

    // Upper and middle line stores share one RAM word: {upper, middle}.
    sem_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata ({mid_pix, r_data}),
        .i_re    (pix_acc),
        .i_raddr (r_in_col),
        .o_rdata (ram_rdata)
    );

    sem_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_sq    (r_sq),
        .o_valid (sqrt_valid),
        .o_mag   (sqrt_mag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_win     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (pix_acc) begin
                        r_state <= S_READ;
                        if (in_wrap) begin
                            r_in_col <= '0;
                            if (r_in_row != ROW_SAT) begin
                                r_in_row <= r_in_row + 2'd1;
                            end
                        end else begin
                            r_in_col <= r_in_col + CW'(1);
                        end
                    end
                end
                S_READ: begin
                    for (int r = 0; r < 3; r++) begin
                        r_win[r*3]   <= r_win[r*3+1];
                        r_win[r*3+1] <= r_win[r*3+2];
                    end
                    r_win[2] <= up_pix;
                    r_win[5] <= mid_pix;
                    r_win[8] <= r_data;
                    if (r_emit) begin
                        r_state <= S_GRAD;
                        if (cur_last) begin
                            r_in_col  <= '0;
                            r_in_row  <= '0;
                            r_out_col <= '0;
                            r_out_row <= '0;
                        end else if (col_end) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + ORW'(1);
                        end else begin
                            r_out_col <= r_out_col + CW'(1);
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_GRAD: begin
                    r_state <= S_SQUARE;
                end
                S_SQUARE: begin
                    r_state <= S_LAUNCH;
                end
                S_LAUNCH: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [2*GRAD_W-1:0] px;
        logic signed [2*GRAD_W-1:0] py;
        if (pix_acc) begin
            r_data <= i_pix.payload.mode ? '0 : i_pix.payload.pixel_in;
            r_idx  <= r_in_col;
            r_emit <= emit_now;
        end
        if (r_state == S_READ) begin
            r_mask.top    <= (r_out_row == '0);
            r_mask.bottom <= row_end;
            r_mask.left   <= (r_out_col == '0);
            r_mask.right  <= col_end;
            r_last        <= cur_last;
        end
        if (r_state == S_GRAD) begin
            for (int k = 0; k < NUM_CHAN; k++) begin
                r_grad[k] <= chan_grad(r_win, r_mask, k);
            end
        end
        if (r_state == S_SQUARE) begin
            for (int k = 0; k < NUM_CHAN; k++) begin
                px = (2*GRAD_W)'(r_grad[k].gx) * (2*GRAD_W)'(r_grad[k].gx);
                py = (2*GRAD_W)'(r_grad[k].gy) * (2*GRAD_W)'(r_grad[k].gy);
                r_sq[k] <= SQ_W'(px[SQ_W-2:0]) + SQ_W'(py[SQ_W-2:0]);
            end
        end
        if (out_load) begin
            r_out.pixel_out  <= sqrt_mag;
            r_out.last_pixel <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_edge.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_edge.valid   = r_out_valid;
    assign o_edge.payload = r_out;

    `SEM_ASSERT_NEXT(a_accept_read, i_clk, i_rst_n, pix_acc, r_state == S_READ, "Accepted pixel did not start a line read.")
    `SEM_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, (r_state == S_READ) && r_emit && cur_last, (r_in_col == '0) && (r_in_row == '0) && (r_out_col == '0) && (r_out_row == '0), "Frame end did not clear the counters.")
    `SEM_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, (r_state == S_ROOT) && sqrt_valid && r_out_valid && !o_edge.ready, (r_state == S_ROOT) && r_out_valid, "Result dropped while output stalled.")
endmodule
